// ===== sv/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg
// shared types, constants and helpers for the tea block cipher pipeline
// ----------------------------------------------------------------------------
package tcb_pkg;

   localparam int unsigned ROUNDS     = 32;
   localparam int unsigned STAGES     = 2 * ROUNDS;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

   // register map of the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      KEY_WORD0_IDX = 8'd0,
      KEY_WORD1_IDX = 8'd1,
      KEY_WORD2_IDX = 8'd2,
      KEY_WORD3_IDX = 8'd3
   } tcb_csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] k0;
      logic [WORD_W-1:0] k1;
      logic [WORD_W-1:0] k2;
      logic [WORD_W-1:0] k3;
   } tcb_key_type;

   // one pipeline slot
   typedef struct packed {
      logic              valid;
      logic              decrypt;
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } tcb_stage_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } tcb_result_type;

   // delta times a round count, wrapped to the word
   function automatic logic [WORD_W-1:0] round_sum(input int unsigned mult);
      logic [63:0] prod;
      prod = 64'(DELTA) * 64'(mult);
      return prod[WORD_W-1:0];
   endfunction

endpackage

// ===== sv/tcb_req_if.sv =====
// ----------------------------------------------------------------------------
// tcb_req_if
// request channel: one plaintext or ciphertext block plus direction
// ----------------------------------------------------------------------------
interface tcb_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcb_pkg::WORD_W-1:0]  left_word;
   logic [tcb_pkg::WORD_W-1:0]  right_word;
   logic                        decrypt;

   modport source (output valid, output left_word, output right_word, output decrypt,
                   input ready);
   modport sink   (input valid, input left_word, input right_word, input decrypt,
                   output ready);
endinterface

// ===== sv/tcb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcb_rsp_if
// response channel: one processed block
// ----------------------------------------------------------------------------
interface tcb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcb_pkg::WORD_W-1:0]  out_left_word;
   logic [tcb_pkg::WORD_W-1:0]  out_right_word;

   modport source (output valid, output out_left_word, output out_right_word,
                   input ready);
   modport sink   (input valid, input out_left_word, input out_right_word,
                   output ready);
endinterface

// ===== sv/tcb_key_regs.sv =====
// ----------------------------------------------------------------------------
// tcb_key_regs
// four 32-bit key registers behind a plain write port
// ----------------------------------------------------------------------------
module tcb_key_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tcb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcb_pkg::WORD_W-1:0]       csr_wdata,
   output tcb_pkg::tcb_key_type             keys
);

   tcb_pkg::tcb_key_type key_ff;
   tcb_pkg::tcb_key_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tcb_pkg::KEY_WORD0_IDX: key_in.k0 = csr_wdata;
            tcb_pkg::KEY_WORD1_IDX: key_in.k1 = csr_wdata;
            tcb_pkg::KEY_WORD2_IDX: key_in.k2 = csr_wdata;
            tcb_pkg::KEY_WORD3_IDX: key_in.k3 = csr_wdata;
            default: ; // writes outside the map are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign keys = key_ff;

endmodule

// ===== sv/tcb_half_round.sv =====
// ----------------------------------------------------------------------------
// tcb_half_round
// one registered half round: one word updated from the other
// ----------------------------------------------------------------------------
module tcb_half_round (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        half_sel,   // 0 first half, 1 second half
   input  logic [tcb_pkg::WORD_W-1:0]  enc_sum,
   input  logic [tcb_pkg::WORD_W-1:0]  dec_sum,
   input  tcb_pkg::tcb_key_type        keys,
   input  tcb_pkg::tcb_stage_type      stage_in,
   output tcb_pkg::tcb_stage_type      stage_out
);

   tcb_pkg::tcb_stage_type      stage_ff;
   tcb_pkg::tcb_stage_type      stage_in_q;
   logic                        upd_right;
   logic [tcb_pkg::WORD_W-1:0]  src;
   logic [tcb_pkg::WORD_W-1:0]  dst;
   logic [tcb_pkg::WORD_W-1:0]  ka;
   logic [tcb_pkg::WORD_W-1:0]  kb;
   logic [tcb_pkg::WORD_W-1:0]  sum;
   logic [tcb_pkg::WORD_W-1:0]  mix;
   logic [tcb_pkg::WORD_W-1:0]  dst_new;

   // encrypt: left then right; decrypt: right then left
   assign upd_right = half_sel ^ stage_in.decrypt;
   assign src = upd_right ? stage_in.left  : stage_in.right;
   assign dst = upd_right ? stage_in.right : stage_in.left;
   assign ka  = upd_right ? keys.k2 : keys.k0;
   assign kb  = upd_right ? keys.k3 : keys.k1;
   assign sum = stage_in.decrypt ? dec_sum : enc_sum;

   assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
   assign dst_new = stage_in.decrypt ? (dst - mix) : (dst + mix);

   always_comb begin
      stage_in_q = stage_in;
      if (upd_right) begin
         stage_in_q.right = dst_new;
      end else begin
         stage_in_q.left = dst_new;
      end
   end

   // only the valid bit is reset, the data just follows it
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.decrypt <= stage_in_q.decrypt;
         stage_ff.left    <= stage_in_q.left;
         stage_ff.right   <= stage_in_q.right;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== sv/tcb_out_skid.sv =====
// ----------------------------------------------------------------------------
// tcb_out_skid
// output register plus one skid entry; holds the pipeline when full
// ----------------------------------------------------------------------------
module tcb_out_skid (
   input  logic                     clock,
   input  logic                     reset,
   input  tcb_pkg::tcb_stage_type   last_stage,
   input  logic                     rsp_ready,
   output logic                     advance,
   output logic                     skid_full,
   output tcb_pkg::tcb_result_type  result
);

   logic                        out_valid_ff, out_valid_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic [tcb_pkg::WORD_W-1:0]  out_left_ff, out_left_in;
   logic [tcb_pkg::WORD_W-1:0]  out_right_ff, out_right_in;
   logic [tcb_pkg::WORD_W-1:0]  skid_left_ff, skid_left_in;
   logic [tcb_pkg::WORD_W-1:0]  skid_right_ff, skid_right_in;
   logic                        take;
   logic                        incoming;

   assign advance  = !skid_valid_ff;
   assign take     = out_valid_ff && rsp_ready;
   assign incoming = advance && last_stage.valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_left_in   = out_left_ff;
      out_right_in  = out_right_ff;
      skid_valid_in = skid_valid_ff;
      skid_left_in  = skid_left_ff;
      skid_right_in = skid_right_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_left_in   = skid_left_ff;
            out_right_in  = skid_right_ff;
            skid_valid_in = 1'b0;
         end
      end else if (incoming) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_left_in  = last_stage.left;
            out_right_in = last_stage.right;
         end else begin
            skid_valid_in = 1'b1;
            skid_left_in  = last_stage.left;
            skid_right_in = last_stage.right;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_left_ff   <= out_left_in;
      out_right_ff  <= out_right_in;
      skid_left_ff  <= skid_left_in;
      skid_right_ff <= skid_right_in;
   end

   assign skid_full    = skid_valid_ff;
   assign result.valid = out_valid_ff;
   assign result.left  = out_left_ff;
   assign result.right = out_right_ff;

endmodule

// ===== sv/tea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher
// tea encrypt/decrypt of 64-bit blocks, one half round per pipeline stage
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req_chan  in    valid/ready      left_word, right_word, decrypt
//  rsp_chan  out   valid/ready      out_left_word, out_right_word
//  csr_*     in    csr_wr_en only   csr_index, csr_wdata (key words 0..3)
//
//  one request accepted per cycle while the skid entry is empty; data passes
//  one stage per half round, then the output register
//  the whole pipeline holds while the skid entry is full; req_chan.ready is
//  a register output (skid entry empty), so no path runs from rsp to req
//  synchronous active-high reset clears valid bits and the key words
//  key writes are expected only while no request is in flight
// ----------------------------------------------------------------------------
module tea_block_cipher (
   input  logic                             clock,
   input  logic                             reset,
   tcb_req_if.sink                          req_chan,
   tcb_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [tcb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcb_pkg::WORD_W-1:0]       csr_wdata
);

   tcb_pkg::tcb_key_type     keys;
   tcb_pkg::tcb_stage_type   pipe [0:tcb_pkg::STAGES];
   tcb_pkg::tcb_result_type  result;
   logic                     advance;
   logic                     skid_full;

   // key registers
   tcb_key_regs u_keys (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .keys      (keys)
   );

   // request enters the first stage whenever the pipeline advances
   assign req_chan.ready  = advance;
   assign pipe[0].valid   = req_chan.valid;
   assign pipe[0].decrypt = req_chan.decrypt;
   assign pipe[0].left    = req_chan.left_word;
   assign pipe[0].right   = req_chan.right_word;

   // stage k is half (k % 2) of round k / 2; the running sum of each round is
   // a constant, counted up for encryption and down for decryption
   for (genvar k = 0; k < tcb_pkg::STAGES; k++) begin : g_stage
      localparam int unsigned RND = k / 2;
      localparam logic [tcb_pkg::WORD_W-1:0] ENC_SUM = tcb_pkg::round_sum(RND + 1);
      localparam logic [tcb_pkg::WORD_W-1:0] DEC_SUM =
         tcb_pkg::round_sum(tcb_pkg::ROUNDS - RND);
      localparam logic HALF = ((k % 2) == 1);

      tcb_half_round u_half (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .half_sel  (HALF),
         .enc_sum   (ENC_SUM),
         .dec_sum   (DEC_SUM),
         .keys      (keys),
         .stage_in  (pipe[k]),
         .stage_out (pipe[k+1])
      );
   end

   // output register and skid entry
   tcb_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .last_stage (pipe[tcb_pkg::STAGES]),
      .rsp_ready  (rsp_chan.ready),
      .advance    (advance),
      .skid_full  (skid_full),
      .result     (result)
   );

   assign rsp_chan.valid          = result.valid;
   assign rsp_chan.out_left_word  = result.left;
   assign rsp_chan.out_right_word = result.right;

   // the skid entry only holds data behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> result.valid)
      else $error("skid entry full while output register empty");

   // the skid entry fills only when the output was full and not taken
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full) |-> $past(result.valid && !rsp_chan.ready))
      else $error("skid entry filled without a stalled response");

   // a held pipeline keeps its last stage
   a_hold_last_stage: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (pipe[tcb_pkg::STAGES].valid == $past(pipe[tcb_pkg::STAGES].valid)))
      else $error("last stage changed during a stall");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the tea block cipher pipeline: keys are loaded
// through the csr port while the pipe is empty, blocks are streamed in both
// directions under random back-pressure and every processed block is compared
// against an in-bench tea predictor in arrival order
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WORD_BITS = tcb_pkg::WORD_W;
   localparam int unsigned IDX_BITS  = tcb_pkg::CSR_INDEX_W;

   typedef struct packed {
      logic [WORD_BITS-1:0] left;
      logic [WORD_BITS-1:0] right;
      logic                 decrypt;
   } tea_block_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] left;
      logic [WORD_BITS-1:0] right;
   } tea_words_type;

   // csr map in write order
   localparam tcb_pkg::tcb_csr_index_type KEY_REGS [4] =
      '{tcb_pkg::KEY_WORD0_IDX, tcb_pkg::KEY_WORD1_IDX,
        tcb_pkg::KEY_WORD2_IDX, tcb_pkg::KEY_WORD3_IDX};

   localparam int unsigned CYCLE_LIMIT       = 1_000_000;
   localparam int unsigned REPORT_LIMIT      = 10;
   // receiver goes deaf for a while once this many blocks came back
   localparam int unsigned LONG_STALL_AT     = 200;
   localparam int unsigned LONG_STALL_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_wr_en = 1'b0;
   logic [IDX_BITS-1:0]  csr_index = '0;
   logic [WORD_BITS-1:0] csr_wdata = '0;

   tcb_req_if req_if ();
   tcb_rsp_if rsp_if ();

   tea_block_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of the key, changed only while the pipe is empty
   tcb_pkg::tcb_key_type cipher_key = '0;

   tea_block_type  block_backlog [$];     // requests not yet offered
   tea_words_type  expected_blocks [$];   // predicted results, oldest first

   int unsigned fail_count      = 0;
   int unsigned blocks_returned = 0;
   int unsigned cycle_count     = 0;
   int unsigned send_gap        = 0;
   int unsigned hold_cycles     = 0;
   int unsigned req_steady      = 0;
   int unsigned rsp_steady      = 0;
   int unsigned long_hold_left  = 0;
   logic        long_hold_done  = 1'b0;

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // one half round: shifted copies of x folded with the round sum and two key words
   function automatic logic [WORD_BITS-1:0] feistel_mix(logic [WORD_BITS-1:0] x,
                                                        logic [WORD_BITS-1:0] sum,
                                                        logic [WORD_BITS-1:0] ka,
                                                        logic [WORD_BITS-1:0] kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

   // full tea transform of one request under the current key
   function automatic tea_words_type tea_process(tea_block_type blk);
      logic [WORD_BITS-1:0] l;
      logic [WORD_BITS-1:0] r;
      logic [WORD_BITS-1:0] sum;
      tea_words_type        res;
      l = blk.left;
      r = blk.right;
      if (!blk.decrypt) begin
         sum = tcb_pkg::DELTA;
         for (int n = 0; n < tcb_pkg::ROUNDS; n++) begin
            l += feistel_mix(r, sum, cipher_key.k0, cipher_key.k1);
            r += feistel_mix(l, sum, cipher_key.k2, cipher_key.k3);
            sum += tcb_pkg::DELTA;
         end
      end else begin
         // reverse schedule starts at delta times the round count, wrapped
         sum = tcb_pkg::DELTA * WORD_BITS'(tcb_pkg::ROUNDS);
         for (int n = 0; n < tcb_pkg::ROUNDS; n++) begin
            r -= feistel_mix(l, sum, cipher_key.k2, cipher_key.k3);
            l -= feistel_mix(r, sum, cipher_key.k0, cipher_key.k1);
            sum -= tcb_pkg::DELTA;
         end
      end
      res.left  = l;
      res.right = r;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // shared helpers
   // ---------------------------------------------------------------------------

   // idle length: mostly none or short, now and then long, with bursts of no idling
   function automatic int unsigned draw_gap(inout int unsigned steady);
      int unsigned roll;
      if (steady > 0) begin
         steady--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         steady = $urandom_range(40, 160);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // ---------------------------------------------------------------------------
   // request driver: offers backlog entries, predicts on each accepted request
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      tea_block_type blk;
      logic          offer;
      if (!reset) begin
         offer = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            blk.left    = req_if.left_word;
            blk.right   = req_if.right_word;
            blk.decrypt = req_if.decrypt;
            expected_blocks.push_back(tea_process(blk));
            offer = 1'b0;
         end
         // valid stays up while a request waits, else maybe load the next one
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (block_backlog.size() > 0) begin
               blk = block_backlog.pop_front();
               req_if.left_word  <= blk.left;
               req_if.right_word <= blk.right;
               req_if.decrypt    <= blk.decrypt;
               offer = 1'b1;
               send_gap = draw_gap(req_steady);
            end
         end
         req_if.valid <= offer;
      end
   end

   // ---------------------------------------------------------------------------
   // long receiver hold-off: one stretch mid-run so the pipe fills and stalls
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
      end else if (!long_hold_done && blocks_returned >= LONG_STALL_AT) begin
         long_hold_left <= LONG_STALL_CYCLES;
         long_hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor: checks each accepted block, then throttles ready
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      tea_words_type seen;
      tea_words_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.left  = rsp_if.out_left_word;
            seen.right = rsp_if.out_right_word;
            if (expected_blocks.size() == 0) begin
               report_failure($sformatf("unexpected response %h_%h", seen.left, seen.right));
            end else begin
               want = expected_blocks.pop_front();
               if (seen.left !== want.left)
                  report_failure($sformatf("response %0d out_left_word: expected %h got %h",
                                           blocks_returned, want.left, seen.left));
               if (seen.right !== want.right)
                  report_failure($sformatf("response %0d out_right_word: expected %h got %h",
                                           blocks_returned, want.right, seen.right));
            end
            blocks_returned++;
            hold_cycles = draw_gap(rsp_steady);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (long_hold_left == 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL tea_block_cipher");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   task automatic queue_block(logic [WORD_BITS-1:0] l, logic [WORD_BITS-1:0] r, logic dec);
      tea_block_type blk;
      blk.left    = l;
      blk.right   = r;
      blk.decrypt = dec;
      block_backlog.push_back(blk);
   endtask

   // write all four key words; optionally slip in a write to an unmapped index
   task automatic load_key(logic [WORD_BITS-1:0] words [4], bit stray);
      int unsigned stray_slot;
      stray_slot = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         if (stray && i == stray_slot) begin
            // unmapped index, must leave every key word alone
            @(posedge clock);
            csr_wr_en <= 1'b1;
            csr_index <= IDX_BITS'($urandom_range(int'(tcb_pkg::KEY_WORD3_IDX) + 1,
                                                  (1 << IDX_BITS) - 1));
            csr_wdata <= $urandom;
         end
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= KEY_REGS[i];
         csr_wdata <= words[i];
         unique case (KEY_REGS[i])
            tcb_pkg::KEY_WORD0_IDX: cipher_key.k0 = words[i];
            tcb_pkg::KEY_WORD1_IDX: cipher_key.k1 = words[i];
            tcb_pkg::KEY_WORD2_IDX: cipher_key.k2 = words[i];
            tcb_pkg::KEY_WORD3_IDX: cipher_key.k3 = words[i];
            default: ;
         endcase
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // key word biased toward the extremes
   function automatic logic [WORD_BITS-1:0] pick_key_word();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return '0;
      if (roll < 24) return '1;
      return $urandom;
   endfunction

   // sender pauses until every predicted block is back
   task automatic wait_drained();
      while (block_backlog.size() != 0 || req_if.valid || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // corner blocks in both directions plus one round trip
   task automatic queue_directed_blocks();
      tea_block_type plain;
      tea_words_type cipher;
      queue_block('0, '0, 1'b0);
      queue_block('0, '0, 1'b1);
      queue_block('1, '1, 1'b0);
      queue_block('1, '1, 1'b1);
      queue_block('1, '0, 1'b0);
      queue_block('0, '1, 1'b1);
      queue_block(32'h5555_5555, 32'haaaa_aaaa, 1'b0);
      queue_block(32'haaaa_aaaa, 32'h5555_5555, 1'b1);
      queue_block(32'h8000_0000, 32'h0000_0001, 1'b0);
      queue_block(32'h0000_0001, 32'h8000_0000, 1'b1);
      plain = '{left: 32'h0123_4567, right: 32'h89ab_cdef, decrypt: 1'b0};
      block_backlog.push_back(plain);
      // decrypting the ciphertext must give the plaintext back
      cipher = tea_process(plain);
      queue_block(cipher.left, cipher.right, 1'b1);
   endtask

   // random blocks, a quarter of them followed by their inverse
   task automatic queue_random_blocks(int unsigned count);
      int unsigned    queued;
      tea_block_type  blk;
      tea_words_type  res;
      queued = 0;
      while (queued < count) begin
         blk.left    = $urandom;
         blk.right   = $urandom;
         blk.decrypt = $urandom_range(0, 1);
         block_backlog.push_back(blk);
         queued++;
         if ($urandom_range(0, 3) == 0) begin
            res = tea_process(blk);
            queue_block(res.left, res.right, !blk.decrypt);
            queued++;
         end
      end
   endtask

   initial begin
      logic [WORD_BITS-1:0] words [4];
      // known levels on every dut input before the first edge
      req_if.valid      = 1'b0;
      req_if.left_word  = '0;
      req_if.right_word = '0;
      req_if.decrypt    = 1'b0;
      rsp_if.ready      = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // key still at its reset value of zero
      queue_directed_blocks();
      wait_drained();

      // all-ones key, with a write to an unmapped index mixed in
      words = '{default: '1};
      load_key(words, 1'b1);
      queue_directed_blocks();
      wait_drained();

      // long random phase, carries the receiver hold-off
      foreach (words[i]) words[i] = pick_key_word();
      load_key(words, 1'b1);
      queue_random_blocks(700);
      wait_drained();

      // further key settings
      repeat (5) begin
         foreach (words[i]) words[i] = pick_key_word();
         load_key(words, $urandom_range(0, 1));
         queue_random_blocks(200);
         wait_drained();
      end

      // catch any stray response after the last one
      repeat (2 * tcb_pkg::STAGES) @(posedge clock);
      if (fail_count == 0 && expected_blocks.size() == 0) begin
         $display("PASS tea_block_cipher");
      end else begin
         $display("FAIL tea_block_cipher");
      end
      $finish;
   end

endmodule
